// ===== rtl/core/lcdt_pkg.sv =====
// lcdt_pkg: types and constants shared by the LCD line timing and status block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcdt_pkg;

    localparam int unsigned CNT_W  = 10;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CYC_W  = 8;

    localparam logic [CNT_W-1:0] LINE_CYCLES     = 10'd456;
    localparam logic [CNT_W-1:0] OAM_CYCLES      = 10'd80;
    localparam logic [CNT_W-1:0] TRANSFER_CYCLES = 10'd172;
    localparam logic [CNT_W-1:0] OAM_START       = LINE_CYCLES - OAM_CYCLES;
    localparam logic [CNT_W-1:0] HBLANK_START    = LINE_CYCLES - OAM_CYCLES - TRANSFER_CYCLES;

    localparam logic [LINE_W-1:0] VBLANK_LINE = 8'h90;
    localparam logic [LINE_W-1:0] LAST_LINE   = 8'h99;

    // display modes
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // request codes
    localparam logic REQ_ADVANCE    = 1'b0;
    localparam logic REQ_LINE_RESET = 1'b1;

    // status interrupt enable bit positions
    localparam int unsigned IRQ_EN_HBLANK = 0;
    localparam int unsigned IRQ_EN_VBLANK = 1;
    localparam int unsigned IRQ_EN_OAM    = 2;
    localparam int unsigned IRQ_EN_MATCH  = 3;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_DISPLAY_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_COMPARE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IRQ_ENABLES    = 2'd2;

    typedef struct packed {
        logic              display_enable;
        logic [LINE_W-1:0] line_compare;
        logic [3:0]        status_irq_enables;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  countdown;
        logic [LINE_W-1:0] line;
        logic [1:0]        mode;
        logic              match;
    } state_t;

    typedef struct packed {
        logic [LINE_W-1:0] current_line;
        logic [1:0]        display_mode;
        logic              line_match;
        logic              status_irq;
        logic              vblank_irq;
        logic              draw_line;
    } result_t;

endpackage

// ===== rtl/core/lcdt_cfg_regs.sv =====
// lcdt_cfg_regs: configuration register file of the LCD timing block.
// Depends on lcdt_pkg.
`timescale 1ns / 1ps

module lcdt_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lcdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lcdt_pkg::cfg_t                  cfg
);
    import lcdt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_DISPLAY_ENABLE: cfg_next.display_enable     = cfg_wdata[0];
                CFG_LINE_COMPARE:   cfg_next.line_compare       = cfg_wdata;
                CFG_IRQ_ENABLES:    cfg_next.status_irq_enables = cfg_wdata[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_enable     <= 1'b1;
            cfg_reg.line_compare       <= '0;
            cfg_reg.status_irq_enables <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lcdt_step.sv =====
// lcdt_step: next-state and result logic for one beat of the LCD timing block.
// Purely combinational; depends on lcdt_pkg.
`timescale 1ns / 1ps

module lcdt_step (
    input  lcdt_pkg::cfg_t               cfg,
    input  lcdt_pkg::state_t             state,
    input  logic                         req_type,
    input  logic [lcdt_pkg::CYC_W-1:0]   cycles,
    output lcdt_pkg::state_t             state_next,
    output lcdt_pkg::result_t            result
);
    import lcdt_pkg::*;

    logic [1:0]        mode;
    logic              mode_irq_en;
    logic              match;
    logic              expire;
    logic [LINE_W-1:0] line_base;
    logic [LINE_W-1:0] line_inc;

    always_comb
    begin
        // mode from the line and countdown held before this beat
        if (state.line >= VBLANK_LINE)
        begin
            mode        = MODE_VBLANK;
            mode_irq_en = cfg.status_irq_enables[IRQ_EN_VBLANK];
        end
        else if (state.countdown >= OAM_START)
        begin
            mode        = MODE_OAM;
            mode_irq_en = cfg.status_irq_enables[IRQ_EN_OAM];
        end
        else if (state.countdown >= HBLANK_START)
        begin
            mode        = MODE_TRANSFER;
            mode_irq_en = 1'b0;
        end
        else
        begin
            mode        = MODE_HBLANK;
            mode_irq_en = cfg.status_irq_enables[IRQ_EN_HBLANK];
        end

        match     = (state.line == cfg.line_compare);
        // countdown minus cycles at or below zero means the line is done
        expire    = ({{(CNT_W-CYC_W){1'b0}}, cycles} >= state.countdown);
        line_base = (state.line > LAST_LINE) ? '0 : state.line;
        line_inc  = line_base + 8'd1;

        state_next = state;
        result     = '0;

        if (req_type == REQ_LINE_RESET)
        begin
            state_next.line = '0;
        end
        else if (!cfg.display_enable)
        begin
            state_next.countdown = LINE_CYCLES;
            state_next.line      = '0;
            state_next.mode      = MODE_VBLANK;
        end
        else
        begin
            state_next.mode  = mode;
            state_next.match = match;
            result.status_irq = (mode_irq_en && (mode != state.mode))
                              || (match && cfg.status_irq_enables[IRQ_EN_MATCH]);
            if (expire)
            begin
                state_next.countdown = LINE_CYCLES;
                state_next.line      = (line_inc > LAST_LINE) ? '0 : line_inc;
                result.vblank_irq    = (line_inc == VBLANK_LINE);
                result.draw_line     = (line_inc < VBLANK_LINE);
            end
            else
            begin
                state_next.countdown = state.countdown - {{(CNT_W-CYC_W){1'b0}}, cycles};
                state_next.line      = line_base;
            end
        end

        result.current_line = state_next.line;
        result.display_mode = state_next.mode;
        result.line_match   = state_next.match;
    end

endmodule

// ===== rtl/core/lcd_line_timing_and_status_top.sv =====
// lcd_line_timing_and_status_top: top level of the LCD line timing and status block.
// Depends on lcdt_pkg, lcdt_cfg_regs and lcdt_step.
`timescale 1ns / 1ps

// Tracks LCD scanline timing from elapsed-cycle beats: a line countdown that
// starts at 456, the current line (0..153), the display mode and the line-match
// flag, with status and vblank interrupt pulses and a draw-line flag per beat.
// One input beat is taken every clock while not stalled; each accepted beat yields
// exactly one result beat in the next cycle from the result register. The line
// state registers close a loop through the step logic, setting the rate at one
// beat per clock. Input stall is raised only while a result is held and the output
// side is stalling. Configuration writes are expected only while the block is idle.
module lcd_line_timing_and_status_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [lcdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [lcdt_pkg::CYC_W-1:0]      cycles,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lcdt_pkg::LINE_W-1:0]     current_line,
    output logic [1:0]                      display_mode,
    output logic                            line_match,
    output logic                            status_irq,
    output logic                            vblank_irq,
    output logic                            draw_line
);
    import lcdt_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_accept;

    lcdt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcdt_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .req_type   (req_type),
        .cycles     (cycles),
        .state_next (state_next),
        .result     (step_result)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.countdown <= LINE_CYCLES;
            state_reg.line      <= '0;
            state_reg.mode      <= MODE_HBLANK;
            state_reg.match     <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
                state_reg <= state_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign current_line = result_reg.current_line;
    assign display_mode = result_reg.display_mode;
    assign line_match   = result_reg.line_match;
    assign status_irq   = result_reg.status_irq;
    assign vblank_irq   = result_reg.vblank_irq;
    assign draw_line    = result_reg.draw_line;

endmodule

// ===== rtl/core/lcdt_checker.sv =====
// lcdt_checker: port-level assertions for the LCD timing block, bound to the top.
// Depends on lcd_line_timing_and_status_top and lcdt_pkg.
`timescale 1ns / 1ps

module lcdt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [lcdt_pkg::LINE_W-1:0] current_line,
    input logic                        vblank_irq,
    input logic                        draw_line
);
    import lcdt_pkg::*;

    // every accepted beat shows up as a result on the next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat produced no result");

    // no stall toward the input while the result register is free
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // a taken result with no new beat leaves the output empty
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
        else $error("result beat repeated");

    // line stays in range; vblank pulse only on reaching line 144, not drawn
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((current_line <= LAST_LINE)
                       && (!vblank_irq || (current_line == VBLANK_LINE && !draw_line))))
        else $error("bad line or vblank pulse");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(current_line)))
        else $error("stalled result changed");

endmodule

bind lcd_line_timing_and_status_top lcdt_checker u_lcdt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .current_line (current_line),
    .vblank_irq   (vblank_irq),
    .draw_line    (draw_line)
);
